/* hdl/pct_pkg.sv */
// Shared types, constants and helper functions of the percent decoder.
package pct_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pct_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } pct_out_t;

  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            last;
  } pct_group_t;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      v = 4'(c[3:0] - 4'd1 + HEX_ALPHA_BASE);
    end
    return v;
  endfunction

endpackage

/* hdl/percent_decoder.sv */
// Top level of the streaming URL percent decoder.
// Each accepted request carries one raw byte and an end-of-string flag; the combinational front
// end resolves escapes and query-mode plus signs and builds a group of zero to three decoded
// bytes; any non-empty group is registered into a queue of QUEUE_DEPTH groups. While pop is held,
// the back end hands out one decoded byte per cycle from the oldest group, and a steady stream
// of one byte per cycle in and out is sustained because decoding never produces more bytes than
// it consumes. Full rises only while the group queue is full.
module percent_decoder #(
  parameter int QUEUE_DEPTH = pct_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pct_pkg::pct_in_t  raw_req,
  output logic              empty,
  input  logic              pop,
  output pct_pkg::pct_out_t dec_req,
  input  logic              cfg_we,
  input  logic              cfg_data
);

  logic                take;
  logic                grp_valid;
  pct_pkg::pct_group_t grp;

  assign take = push && !full;

  pct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .raw_req   (raw_req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  pct_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .dec_req   (dec_req)
  );

endmodule

/* hdl/pct_front.sv */
// Front end: classifies each input byte and builds the group of decoded bytes it releases.
module pct_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  pct_pkg::pct_in_t   raw_req,
  input  logic               cfg_we,
  input  logic               cfg_data,
  output logic               grp_valid,
  output pct_pkg::pct_group_t grp
);

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  logic       plus_as_space;
  logic [1:0] pending;
  logic [1:0] pending_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic [7:0] b;
  logic [7:0] b_lit;
  logic       b_hex;
  logic       b_pct;

  assign b     = raw_req.in_byte;
  assign b_hex = pct_pkg::is_hex(b);
  assign b_pct = (b == pct_pkg::PCT_CHAR);
  assign b_lit = (plus_as_space && b == pct_pkg::PLUS_CHAR) ? pct_pkg::SPACE_CHAR : b;

  always_comb begin
    grp          = '0;
    pending_next = pending;
    held_next    = held;
    case (pending)
      PEND_PCT: begin
        if (b_hex) begin
          pending_next = PEND_DIGIT;
          held_next    = b;
        end else begin
          grp.data[0] = pct_pkg::PCT_CHAR;
          if (b_pct) begin
            grp.count    = 2'd1;
            pending_next = PEND_PCT;
          end else begin
            grp.data[1]  = b_lit;
            grp.count    = 2'd2;
            pending_next = PEND_NONE;
          end
        end
      end
      PEND_DIGIT: begin
        if (b_hex) begin
          grp.data[0]  = {pct_pkg::hex_val(held), pct_pkg::hex_val(b)};
          grp.count    = 2'd1;
          pending_next = PEND_NONE;
        end else begin
          grp.data[0] = pct_pkg::PCT_CHAR;
          grp.data[1] = held;
          if (b_pct) begin
            grp.count    = 2'd2;
            pending_next = PEND_PCT;
          end else begin
            grp.data[2]  = b_lit;
            grp.count    = 2'd3;
            pending_next = PEND_NONE;
          end
        end
      end
      default: begin
        if (b_pct) begin
          pending_next = PEND_PCT;
        end else begin
          grp.data[0]  = b_lit;
          grp.count    = 2'd1;
          pending_next = PEND_NONE;
        end
      end
    endcase
    if (raw_req.in_last) begin
      if (pending_next == PEND_PCT) begin
        grp.data[grp.count] = pct_pkg::PCT_CHAR;
        grp.count           = grp.count + 2'd1;
      end else if (pending_next == PEND_DIGIT) begin
        grp.data[0] = pct_pkg::PCT_CHAR;
        grp.data[1] = held_next;
        grp.count   = 2'd2;
      end
      grp.last     = 1'b1;
      pending_next = PEND_NONE;
    end
  end

  assign grp_valid = take && (grp.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_as_space <= 1'b0;
      pending       <= PEND_NONE;
    end else begin
      if (cfg_we) begin
        plus_as_space <= cfg_data;
      end
      if (take) begin
        pending <= pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= held_next;
    end
  end

endmodule

/* hdl/pct_back.sv */
// Back end: queue of decoded byte groups and the serialiser that hands them out one byte at a time.
module pct_back #(
  parameter int DEPTH = pct_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                grp_valid,
  input  pct_pkg::pct_group_t grp,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output pct_pkg::pct_out_t   dec_req
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  pct_pkg::pct_group_t queue [DEPTH];
  pct_pkg::pct_group_t head;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [1:0]    idx;
  logic          pop_fire;
  logic          head_done;

  assign head      = queue[rd_ptr];
  assign empty     = (count == CW'(0));
  assign full      = (count == CW'(DEPTH));
  assign pop_fire  = pop && !empty;
  assign head_done = pop_fire && (idx == head.count - 2'd1);

  assign dec_req.out_byte = head.data[idx];
  assign dec_req.out_last = head.last && (idx == head.count - 2'd1);

  always_ff @(posedge clk) begin
    if (grp_valid) begin
      queue[wr_ptr] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      idx    <= 2'd0;
    end else begin
      if (grp_valid) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (head_done) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
        idx    <= 2'd0;
      end else if (pop_fire) begin
        idx <= idx + 2'd1;
      end
      if (grp_valid && !head_done) begin
        count <= count + CW'(1);
      end else if (!grp_valid && head_done) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> !full || head_done)
    else $error("group written into a full queue");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    !empty |-> head.count != 2'd0)
    else $error("queue head holds no bytes");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx < head.count)
    else $error("serialiser index past the end of the head group");

  a_idx_clear_when_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> idx == 2'd0)
    else $error("serialiser index not cleared with the queue empty");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the percent decoder: queued stimulus, a byte-level decode predictor
// and a monitor that compares every decoded byte with the predicted one.
module tb;

  typedef struct {
    pct_pkg::pct_in_t req;
    bit               drain_first;
  } stim_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  pct_pkg::pct_in_t  raw_req = '0;
  logic              empty;
  logic              pop = 1'b0;
  pct_pkg::pct_out_t dec_req;
  logic              cfg_we = 1'b0;
  logic              cfg_data = 1'b0;

  stim_t             pending_q[$];
  pct_pkg::pct_out_t decoded_q[$];
  pct_pkg::pct_out_t want;

  logic       query_mode = 1'b0;
  logic [1:0] held_cnt = 2'd0;
  logic [7:0] held_ch = 8'h00;
  int         step_n = 0;

  bit no_idle = 1'b0;
  int tx_gap = 0;
  int rx_stall = 0;
  int errors = 0;
  int phase_items = 0;

  percent_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .raw_req (raw_req),
    .empty   (empty),
    .pop     (pop),
    .dec_req (dec_req),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(8, 0);
  endfunction

  function automatic logic hex_digit(logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return (c >= "0" && c <= "9") || (lc >= "a" && lc <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(logic [7:0] c);
    if (c <= "9") begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  // At most three decoded bytes leave for one request; any further byte is dropped.
  function automatic void queue_byte(logic [7:0] b);
    pct_pkg::pct_out_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    if (step_n < 3) begin
      decoded_q = {decoded_q, r};
    end
    step_n++;
  endfunction

  function automatic void take_plain(logic [7:0] b);
    if (b == pct_pkg::PCT_CHAR) begin
      held_cnt = 2'd1;
    end else if (query_mode && b == pct_pkg::PLUS_CHAR) begin
      queue_byte(pct_pkg::SPACE_CHAR);
    end else begin
      queue_byte(b);
    end
  endfunction

  function automatic void predict_decode(pct_pkg::pct_in_t it);
    int first;
    first = decoded_q.size();
    step_n = 0;
    case (held_cnt)
      2'd1: begin
        if (hex_digit(it.in_byte)) begin
          held_ch = it.in_byte;
          held_cnt = 2'd2;
        end else begin
          held_cnt = 2'd0;
          queue_byte(pct_pkg::PCT_CHAR);
          take_plain(it.in_byte);
        end
      end
      2'd2: begin
        if (hex_digit(it.in_byte)) begin
          held_cnt = 2'd0;
          queue_byte({nibble_of(held_ch), nibble_of(it.in_byte)});
        end else begin
          held_cnt = 2'd0;
          queue_byte(pct_pkg::PCT_CHAR);
          take_plain(held_ch);
          take_plain(it.in_byte);
        end
        if (held_cnt != 2'd2) begin
          held_ch = 8'h00;
        end
      end
      default: begin
        held_cnt = 2'd0;
        take_plain(it.in_byte);
      end
    endcase
    if (it.in_last) begin
      if (held_cnt == 2'd1) begin
        queue_byte(pct_pkg::PCT_CHAR);
      end else if (held_cnt == 2'd2) begin
        queue_byte(pct_pkg::PCT_CHAR);
        queue_byte(held_ch);
      end
      held_cnt = 2'd0;
      held_ch = 8'h00;
      if (decoded_q.size() > first) begin
        decoded_q[decoded_q.size() - 1].out_last = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_decode(raw_req);
        tx_gap = draw_gap();
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain_first && decoded_q.size() != 0)) begin
        raw_req <= pending_q[0].req;
        push <= 1'b1;
        void'(pending_q.pop_front());
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected request: expected none, actual byte %h last %b",
                   $time, dec_req.out_byte, dec_req.out_last);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (dec_req.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.out_byte, dec_req.out_byte);
            errors++;
          end
          if (dec_req.out_last !== want.out_last) begin
            $display("%0t: out_last mismatch: expected %b, actual %b",
                     $time, want.out_last, dec_req.out_last);
            errors++;
          end
        end
        rx_stall = draw_gap();
      end
      if (rx_stall > 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic add_item(logic [7:0] b, logic last, bit drain);
    stim_t s;
    s.req.in_byte = b;
    s.req.in_last = last;
    s.drain_first = drain;
    pending_q = {pending_q, s};
    phase_items++;
  endtask

  task automatic add_text(string txt, bit last_on_end);
    for (int i = 0; i < txt.len(); i++) begin
      add_item(txt[i], last_on_end && (i == txt.len() - 1), 1'b0);
    end
  endtask

  function automatic logic [7:0] rand_hex();
    string hex_set;
    hex_set = "0123456789abcdefABCDEF";
    return hex_set[$urandom_range(21, 0)];
  endfunction

  // Strings are built from well-formed escapes with random digits, plus signs, broken escapes and
  // arbitrary bytes, some of them carrying a stray end flag.
  task automatic add_random_string();
    int tokens;
    tokens = $urandom_range(6, 1);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(9, 0))
        0, 1, 2: begin
          add_item(pct_pkg::PCT_CHAR, 1'b0, 1'b0);
          add_item(rand_hex(), 1'b0, 1'b0);
          add_item(rand_hex(), 1'b0, 1'b0);
        end
        3: begin
          add_item(pct_pkg::PCT_CHAR, 1'b0, 1'b0);
          add_item(rand_hex(), 1'b0, 1'b0);
          add_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
        end
        4: add_item(pct_pkg::PLUS_CHAR, 1'b0, 1'b0);
        5: add_item(pct_pkg::PCT_CHAR, 1'b0, 1'b0);
        6: add_item(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b0);
        default: add_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      endcase
    end
    pending_q[pending_q.size() - 1].req.in_last = 1'b1;
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_q.size() != 0 || push || decoded_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    query_mode = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count, bit drain_at_start);
    phase_items = 0;
    add_random_string();
    pending_q[0].drain_first = drain_at_start;
    while (phase_items < count) begin
      add_random_string();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_text("%41", 1'b1);
    add_text("%6a%Fb", 1'b0);
    add_text("%zg", 1'b1);
    add_text("%%4", 1'b1);
    add_text("%", 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_text("%4%", 1'b1);
    wait_idle();

    write_mode(1'b1);
    add_text("+", 1'b1);
    add_text("%2B+", 1'b1);
    wait_idle();

    random_phase(40, 1'b0);
    wait_idle();

    write_mode(1'b0);
    random_phase(40, 1'b0);
    wait_idle();

    write_mode(1'b1);
    no_idle = 1'b1;
    random_phase(20, 1'b0);
    wait_idle();
    no_idle = 1'b0;
    random_phase(20, 1'b1);
    wait_idle();

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
